/* rtl/tla_pkg.sv */
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types and constants of the tiled-to-linear address generator:
// beat layouts, register indexes, register widths and reset values.
// ----------------------------------------------------------------------------
package tla_pkg;

   // Dimension limit default (pixels)
   localparam int MAX_DIMENSION_DEF = 4096;

   // Field widths
   localparam int COORD_W  = 12;
   localparam int DIM_W    = 13;
   localparam int PB_W     = 5;
   localparam int OFFSET_W = 28;

   // Beat layouts, padded to whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 * OFFSET_W + 1);

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = DIM_W;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_PIXEL_BYTES  = 2'd2,
      CSR_SPLIT_MODE   = 2'd3
   } csr_index_type;

   // Register reset values
   localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd64;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd64;
   localparam logic [PB_W-1:0]  PB_RST     = 5'd4;
   localparam logic             SPLIT_RST  = 1'b0;

   // Alignment: width a multiple of 16, height a multiple of 8
   localparam logic [DIM_W-1:0] WIDTH_ALIGN_MASK  = 13'h000F;
   localparam logic [DIM_W-1:0] HEIGHT_ALIGN_MASK = 13'h0007;

endpackage

/* rtl/tiled_to_linear_address_core.sv */
// ----------------------------------------------------------------------------
// tiled_to_linear_address_core
// Per-pixel address generator: byte offset in a 4x4-tiled source buffer
// (plain or two-half split layout) and in the linear image.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel coordinate per beat; rsp_* returns one beat per
//   request with the tiled source offset, the linear offset and an outside
//   flag (offsets are zero when the coordinate lies outside the image).
//   csr_* sets width, height, bytes per pixel and split mode; write only
//   while no request is in flight. Width and height are clamped to
//   MAX_DIMENSION and rounded down to multiples of 16 and 8 on the write.
//   Throughput: one beat per cycle unless stalled; three register stages
//   (products, sums, bytes-per-pixel scaling), each stage with its own valid bit.
//   Stall: when rsp_tready is low the stages fill up and req_tready drops
//   once all three hold a beat; nothing is dropped or repeated.
//   Reset (synchronous): empties the pipe and restores 64x64, 4 bytes per
//   pixel, plain tiling.
// ----------------------------------------------------------------------------
module tiled_to_linear_address_core #(
   parameter int MAX_DIMENSION = tla_pkg::MAX_DIMENSION_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: pixel_x [11:0], pixel_y [23:12]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tla_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: source_offset [27:0], linear_offset [55:28],
   //            outside_image [56], zero [63:57]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tla_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [tla_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [tla_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tla_pkg::*;

   localparam logic [DIM_W+1:0] MaxDim = (DIM_W+2)'(MAX_DIMENSION);

   // Clamp to the dimension limit, then drop the unaligned low bits
   function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] mask);
      logic [DIM_W-1:0] res;
      res = v;
      if ({2'b00, v} > MaxDim) begin
         res = MaxDim[DIM_W-1:0];
      end
      return res & ~mask;
   endfunction

   // Configuration registers
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [PB_W-1:0]  pb_ff;
   logic             split_ff;
   csr_index_type    csr_idx;

   assign csr_idx = csr_index_type'(csr_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= limit_dim(WIDTH_RST, WIDTH_ALIGN_MASK);
         height_ff <= limit_dim(HEIGHT_RST, HEIGHT_ALIGN_MASK);
         pb_ff     <= PB_RST;
         split_ff  <= SPLIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_idx)
            CSR_IMAGE_WIDTH:  width_ff  <= limit_dim(csr_wdata, WIDTH_ALIGN_MASK);
            CSR_IMAGE_HEIGHT: height_ff <= limit_dim(csr_wdata, HEIGHT_ALIGN_MASK);
            CSR_PIXEL_BYTES:  pb_ff     <= csr_wdata[PB_W-1:0];
            CSR_SPLIT_MODE:   split_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when empty or when its beat moves on
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   assign en3        = !v3_ff || rsp_tready;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: coordinate split and the three products
   logic [COORD_W-1:0] px, py;
   logic [10:0]        tiles_x;
   logic [9:0]         half_rows;
   logic [9:0]         row_sel;
   logic               half_sel;
   logic [20:0]        half_prod;

   logic [24:0] lin_prod_in,  lin_prod_ff;
   logic [20:0] half_term_in, half_term_ff;
   logic [20:0] row_prod_in,  row_prod_ff;
   logic [9:0]  col_in,       col_ff;
   logic [3:0]  inner_in,     inner_ff;
   logic [COORD_W-1:0] x1_ff;
   logic        outside_in,   out1_ff;

   always_comb begin
      px        = req_tdata[COORD_W-1:0];
      py        = req_tdata[2*COORD_W-1:COORD_W];
      tiles_x   = width_ff[DIM_W-1:2];
      half_rows = height_ff[DIM_W-1:3];
      // split: half = (row bit 0) xor (column bit 1)
      half_sel  = split_ff && (py[2] ^ px[3]);
      row_sel   = split_ff ? {1'b0, py[COORD_W-1:3]} : py[COORD_W-1:2];
      col_in    = split_ff ? {px[COORD_W-1:4], py[2], px[2]} : px[COORD_W-1:2];
      inner_in  = {py[1:0], px[1:0]};
      half_prod = {11'b0, half_rows} * {10'b0, tiles_x};
      half_term_in = half_sel ? half_prod : 21'd0;
      row_prod_in  = {11'b0, row_sel} * {10'b0, tiles_x};
      lin_prod_in  = {13'b0, py} * {12'b0, width_ff};
      outside_in   = ({1'b0, px} >= width_ff) || ({1'b0, py} >= height_ff);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         lin_prod_ff  <= lin_prod_in;
         half_term_ff <= half_term_in;
         row_prod_ff  <= row_prod_in;
         col_ff       <= col_in;
         inner_ff     <= inner_in;
         x1_ff        <= px;
         out1_ff      <= outside_in;
      end
   end

   // Stage 2: pixel indexes in both layouts
   logic [21:0] src_tile;
   logic [25:0] src_pix_in, src_pix_ff;
   logic [25:0] lin_pix_in, lin_pix_ff;
   logic        out2_ff;

   always_comb begin
      src_tile   = {1'b0, half_term_ff} + {1'b0, row_prod_ff} + {12'b0, col_ff};
      src_pix_in = {src_tile, inner_ff};
      lin_pix_in = {1'b0, lin_prod_ff} + {14'b0, x1_ff};
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         src_pix_ff <= src_pix_in;
         lin_pix_ff <= lin_pix_in;
         out2_ff    <= out1_ff;
      end
   end

   // Stage 3: scale by bytes per pixel, wrap to the offset width
   logic [30:0]         src_byte, lin_byte;
   logic [OFFSET_W-1:0] src_off_in, src_off_ff;
   logic [OFFSET_W-1:0] lin_off_in, lin_off_ff;
   logic                out3_ff;

   always_comb begin
      src_byte   = {5'b0, src_pix_ff} * {26'b0, pb_ff};
      lin_byte   = {5'b0, lin_pix_ff} * {26'b0, pb_ff};
      src_off_in = out2_ff ? '0 : src_byte[OFFSET_W-1:0];
      lin_off_in = out2_ff ? '0 : lin_byte[OFFSET_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         src_off_ff <= src_off_in;
         lin_off_ff <= lin_off_in;
         out3_ff    <= out2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out3_ff, lin_off_ff, src_off_ff};

endmodule

/* rtl/tla_checker.sv */
// ----------------------------------------------------------------------------
// tla_checker
// Port-level checks of the address generator, bound to the core module.
// ----------------------------------------------------------------------------
module tla_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tla_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tla_pkg::*;

   localparam int OutBit = 2 * OFFSET_W;

   // Pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Outside coordinates give zero offsets
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[OutBit] |-> rsp_tdata[OutBit-1:0] == '0)
      else $error("nonzero offset on outside pixel");

   // Padding bits stay clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:OutBit+1] == '0)
      else $error("rsp_tdata padding not zero");

   // Stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed under stall");

   // Input never stalls while the output side drains
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req_tready low while rsp_tready high");

endmodule

bind tiled_to_linear_address_core tla_checker u_tla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/tiled_to_linear_address_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tiled_to_linear_address_core_tb
// Self-checking bench for the tiled-to-linear address generator. A table of
// directed coordinates, each row with its own geometry, is followed by
// random phases under extreme and random register settings. Every response
// beat is compared with the typed offsets of its row or with a behavioral
// offset calculator; both stream sides idle at random, one phase at full rate.
// ----------------------------------------------------------------------------
module tiled_to_linear_address_core_tb;
   import tla_pkg::*;

   localparam int MAX_DIM       = MAX_DIMENSION_DEF;
   localparam int PIPE_DRAIN    = 6;
   localparam int STALL_LIMIT   = 5000;
   localparam int PHASE_COUNT   = 12;
   localparam int PHASE_ITEMS   = 100;
   localparam int DIRECTED_ROWS = 18;

   typedef struct packed {
      logic [OFFSET_W-1:0] source_offset;
      logic [OFFSET_W-1:0] linear_offset;
      logic                outside_image;
   } offsets_type;

   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [PB_W-1:0]     pixel_bytes;
      logic                split;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic                typed;
      offsets_type         known;
   } coord_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // pixel_x [11:0], pixel_y [23:12]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // source_offset, linear_offset, outside_image
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // register shadow
   logic [DIM_W-1:0]      geo_width;
   logic [DIM_W-1:0]      geo_height;
   logic [PB_W-1:0]       geo_pixel_bytes;
   logic                  geo_split;

   offsets_type           pending_offsets [$];
   int                    mismatches = 0;
   int                    stall_cycles = 0;
   logic                  full_rate;
   coord_row_type         directed_rows [DIRECTED_ROWS];

   tiled_to_linear_address_core #(
      .MAX_DIMENSION (MAX_DIM)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always #6 clock = ~clock;

   // clamp to the dimension limit, then drop the alignment bits
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
                                                  input logic [DIM_W-1:0] align);
      logic [DIM_W-1:0] v;
      v = (raw > MAX_DIM) ? DIM_W'(MAX_DIM) : raw;
      return v & ~align;
   endfunction

   // tiled and linear byte offsets of one pixel under the current registers
   function automatic offsets_type tile_offsets(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y);
      logic [63:0] w, h, tiles_x, tiles_y, r, c, inner, tile_idx, rb, half, col;
      offsets_type o;
      w = 64'(clamp_dim(geo_width, WIDTH_ALIGN_MASK));
      h = 64'(clamp_dim(geo_height, HEIGHT_ALIGN_MASK));
      o = '0;
      if (64'(x) >= w || 64'(y) >= h) begin
         o.outside_image = 1'b1;
         return o;
      end
      tiles_x = w / 4;
      tiles_y = h / 4;
      r       = 64'(y) / 4;
      c       = 64'(x) / 4;
      inner   = (64'(y) % 4) * 4 + (64'(x) % 4);
      if (geo_split) begin
         rb       = r & 64'd1;
         half     = rb ^ ((c >> 1) & 64'd1);
         col      = (c & ~64'd2) | (rb << 1);
         tile_idx = half * (tiles_y / 2) * tiles_x + (r >> 1) * tiles_x + col;
      end else begin
         tile_idx = r * tiles_x + c;
      end
      o.source_offset = OFFSET_W'((tile_idx * 16 + inner) * 64'(geo_pixel_bytes));
      o.linear_offset = OFFSET_W'((64'(y) * w + 64'(x)) * 64'(geo_pixel_bytes));
      return o;
   endfunction

   // wait for the pipe to empty; called at a falling edge, returns at one
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (pending_offsets.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      @(negedge clock);
   endtask

   // write all four registers, one beat each; called at a falling edge
   task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [PB_W-1:0] pb, input logic split);
      csr_wr_en <= 1'b1;
      csr_addr  <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_addr  <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_addr  <= CSR_PIXEL_BYTES;
      csr_wdata <= CSR_DATA_W'(pb);
      @(negedge clock);
      csr_addr  <= CSR_SPLIT_MODE;
      csr_wdata <= CSR_DATA_W'(split);
      @(negedge clock);
      csr_wr_en       <= 1'b0;
      geo_width       = w;
      geo_height      = h;
      geo_pixel_bytes = pb;
      geo_split       = split;
   endtask

   // drive one coordinate beat; called at a falling edge, returns at one
   task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input offsets_type expected);
      while (!full_rate && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      pending_offsets.push_back(expected);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // coordinate mostly inside the current image, sometimes anywhere
   task automatic send_random_coord();
      logic [DIM_W-1:0]   w, h;
      logic [COORD_W-1:0] x, y;
      w = clamp_dim(geo_width, WIDTH_ALIGN_MASK);
      h = clamp_dim(geo_height, HEIGHT_ALIGN_MASK);
      x = COORD_W'($urandom_range(0, 4095));
      y = COORD_W'($urandom_range(0, 4095));
      if ($urandom_range(0, 99) < 80) begin
         if (w != 0) x = COORD_W'($urandom_range(0, w - 1));
         if (h != 0) y = COORD_W'($urandom_range(0, h - 1));
      end
      send_coord(x, y, tile_offsets(x, y));
   endtask

   // response side backpressure
   always @(negedge clock) begin
      rsp_tready <= full_rate || ($urandom_range(0, 99) >= 30);
   end

   // response checker
   always @(posedge clock) begin
      offsets_type exp_o, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.source_offset = rsp_tdata[OFFSET_W-1:0];
         got.linear_offset = rsp_tdata[2*OFFSET_W-1:OFFSET_W];
         got.outside_image = rsp_tdata[2*OFFSET_W];
         if (pending_offsets.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response beat %h", rsp_tdata);
         end else begin
            exp_o = pending_offsets.pop_front();
            if (got !== exp_o) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: src %h/%h lin %h/%h out %b/%b (exp/got)",
                           exp_o.source_offset, got.source_offset,
                           exp_o.linear_offset, got.linear_offset,
                           exp_o.outside_image, got.outside_image);
            end
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      logic [DIM_W-1:0] w, h;
      logic [PB_W-1:0]  pb;
      logic             split;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_wr_en    = 1'b0;
      csr_addr     = CSR_IMAGE_WIDTH;
      csr_wdata    = '0;
      full_rate    = 1'b0;
      geo_width       = WIDTH_RST;
      geo_height      = HEIGHT_RST;
      geo_pixel_bytes = PB_RST;
      geo_split       = SPLIT_RST;

      // width, height, bytes, split, x, y, typed, {source, linear, outside}
      directed_rows = '{
         // reset geometry: corners and the edges just outside
         '{13'd64,   13'd64,   5'd4,  1'b0, 12'd0,    12'd0,    1'b1, '{28'd0, 28'd0, 1'b0}},
         '{13'd64,   13'd64,   5'd4,  1'b0, 12'd63,   12'd63,   1'b1,
           '{28'd16380, 28'd16380, 1'b0}},
         '{13'd64,   13'd64,   5'd4,  1'b0, 12'd64,   12'd0,    1'b1, '{28'd0, 28'd0, 1'b1}},
         '{13'd64,   13'd64,   5'd4,  1'b0, 12'd0,    12'd64,   1'b1, '{28'd0, 28'd0, 1'b1}},
         '{13'd64,   13'd64,   5'd4,  1'b0, 12'd4095, 12'd4095, 1'b1, '{28'd0, 28'd0, 1'b1}},
         '{13'd64,   13'd64,   5'd4,  1'b0, 12'd5,    12'd6,    1'b0, '0},
         // split layout
         '{13'd64,   13'd64,   5'd4,  1'b1, 12'd0,    12'd0,    1'b1, '{28'd0, 28'd0, 1'b0}},
         '{13'd64,   13'd64,   5'd4,  1'b1, 12'd13,   12'd6,    1'b0, '0},
         '{13'd64,   13'd64,   5'd4,  1'b1, 12'd63,   12'd63,   1'b0, '0},
         // oversized dimensions get clamped
         '{13'd8191, 13'd8191, 5'd1,  1'b0, 12'd4095, 12'd4095, 1'b1,
           '{28'd16777215, 28'd16777215, 1'b0}},
         '{13'd8191, 13'd8191, 5'd1,  1'b1, 12'd4095, 12'd4095, 1'b0, '0},
         // unaligned dimensions round down to 96 x 8
         '{13'd100,  13'd13,   5'd2,  1'b0, 12'd95,   12'd7,    1'b0, '0},
         '{13'd100,  13'd13,   5'd2,  1'b0, 12'd96,   12'd0,    1'b1, '{28'd0, 28'd0, 1'b1}},
         '{13'd100,  13'd13,   5'd2,  1'b0, 12'd0,    12'd8,    1'b1, '{28'd0, 28'd0, 1'b1}},
         // dimension rounded to zero: everything outside
         '{13'd15,   13'd64,   5'd4,  1'b0, 12'd0,    12'd0,    1'b1, '{28'd0, 28'd0, 1'b1}},
         '{13'd64,   13'd7,    5'd4,  1'b0, 12'd0,    12'd0,    1'b1, '{28'd0, 28'd0, 1'b1}},
         // offset wraps past 28 bits; zero bytes per pixel
         '{13'd4096, 13'd4096, 5'd31, 1'b0, 12'd4095, 12'd4095, 1'b0, '0},
         '{13'd64,   13'd64,   5'd0,  1'b1, 12'd10,   12'd20,   1'b1, '{28'd0, 28'd0, 1'b0}}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, reprogramming whenever the geometry changes
      foreach (directed_rows[i]) begin
         if (directed_rows[i].width != geo_width || directed_rows[i].height != geo_height ||
             directed_rows[i].pixel_bytes != geo_pixel_bytes ||
             directed_rows[i].split != geo_split) begin
            drain_pipe();
            set_geometry(directed_rows[i].width, directed_rows[i].height,
                         directed_rows[i].pixel_bytes, directed_rows[i].split);
         end
         send_coord(directed_rows[i].x, directed_rows[i].y,
                    directed_rows[i].typed ? directed_rows[i].known :
                    tile_offsets(directed_rows[i].x, directed_rows[i].y));
      end

      // random phases: extreme geometries first, then random ones
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin w = 13'd16;   h = 13'd8;    pb = 5'd1;  split = 1'b0; end
            1: begin w = 13'd4096; h = 13'd4096; pb = 5'd16; split = 1'b1; end
            2: begin w = 13'd8191; h = 13'd8191; pb = 5'd31; split = 1'b1; end
            3: begin w = 13'd16;   h = 13'd8;    pb = 5'd1;  split = 1'b1; end
            4: begin w = 13'd4096; h = 13'd8;    pb = 5'd5;  split = 1'b1; end
            5: begin w = 13'd16;   h = 13'd4096; pb = 5'd3;  split = 1'b0; end
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  w = DIM_W'($urandom_range(0, 8191));
                  h = DIM_W'($urandom_range(0, 8191));
               end else begin
                  w = DIM_W'($urandom_range(1, 256) * 16);
                  h = DIM_W'($urandom_range(1, 512) * 8);
               end
               pb    = PB_W'($urandom_range(0, 31));
               split = 1'($urandom_range(0, 1));
            end
         endcase
         drain_pipe();
         set_geometry(w, h, pb, split);
         full_rate = (p == 1);
         repeat (PHASE_ITEMS) send_random_coord();
      end
      full_rate = 1'b0;

      // wait out the last responses
      req_tvalid <= 1'b0;
      while (pending_offsets.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/tla_pkg.sv
rtl/tiled_to_linear_address_core.sv
rtl/tla_checker.sv
test/tiled_to_linear_address_core_tb.sv
